// File: sv/shs_pkg.sv
package shs_pkg;

   typedef enum logic [2:0] {
      ST_ABSORB,
      ST_PAD,
      ST_ROUND,
      ST_FOLD,
      ST_EMIT
   } shs_state_type;

   typedef enum logic [1:0] {
      BSEL_INPUT,
      BSEL_MARK,
      BSEL_ZERO,
      BSEL_LENGTH
   } shs_bsel_type;

   typedef struct packed {
      logic         init;
      logic         byte_we;
      shs_bsel_type bsel;
      logic         count_en;
      logic         load_work;
      logic         round_en;
      logic [5:0]   rnd;
      logic         fold;
      logic [1:0]   oidx;
   } shs_cmd_type;

   localparam logic [7:0] PAD_MARK = 8'h80;
   localparam logic [5:0] LAST_POS = 6'd63;
   localparam logic [5:0] LAST_RND = 6'd63;
   localparam logic [1:0] LAST_WORD = 2'd3;

   localparam logic [31:0] INIT_HASH [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   localparam logic [31:0] ROUND_K [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

endpackage

// File: sv/shs_datapath.sv
module shs_datapath (
   input  logic                clock,
   input  logic                reset,
   input  shs_pkg::shs_cmd_type cmd,
   input  logic [7:0]          in_byte,
   output logic [5:0]          pos,
   output logic [63:0]         digest
);
   import shs_pkg::*;

   logic [31:0] hash_ff [8];
   logic [31:0] hash_in [8];
   logic [31:0] work_ff [8];
   logic [31:0] work_in [8];
   logic [31:0] w_ff [16];
   logic [31:0] w_in [16];
   logic [23:0] part_ff;
   logic [23:0] part_in;
   logic [5:0]  pos_ff;
   logic [5:0]  pos_in;
   logic [63:0] cnt_ff;
   logic [63:0] cnt_in;

   logic [7:0]  byte_val;
   logic [31:0] sched;
   logic [31:0] t1;
   logic [31:0] t2;
   logic [31:0] big0;
   logic [31:0] big1;
   logic [31:0] ch;
   logic [31:0] maj;

   function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
      return (x >> n) | (x << (32 - n));
   endfunction

   always_comb begin
      case (cmd.bsel)
         BSEL_INPUT:  byte_val = in_byte;
         BSEL_MARK:   byte_val = PAD_MARK;
         BSEL_LENGTH: byte_val = 8'(cnt_ff >> {~pos_ff[2:0], 3'b000});
         default:     byte_val = 8'd0;
      endcase
   end

   // round function and message schedule
   always_comb begin
      big1  = rotr(work_ff[4], 6) ^ rotr(work_ff[4], 11) ^ rotr(work_ff[4], 25);
      big0  = rotr(work_ff[0], 2) ^ rotr(work_ff[0], 13) ^ rotr(work_ff[0], 22);
      ch    = (work_ff[4] & work_ff[5]) ^ (~work_ff[4] & work_ff[6]);
      maj   = (work_ff[0] & work_ff[1]) ^ (work_ff[0] & work_ff[2])
            ^ (work_ff[1] & work_ff[2]);
      t1    = work_ff[7] + big1 + ch + ROUND_K[cmd.rnd] + w_ff[0];
      t2    = big0 + maj;
      sched = (rotr(w_ff[14], 17) ^ rotr(w_ff[14], 19) ^ (w_ff[14] >> 10))
            + w_ff[9]
            + (rotr(w_ff[1], 7) ^ rotr(w_ff[1], 18) ^ (w_ff[1] >> 3))
            + w_ff[0];
   end

   always_comb begin
      hash_in = hash_ff;
      work_in = work_ff;
      w_in    = w_ff;
      part_in = part_ff;
      pos_in  = pos_ff;
      cnt_in  = cnt_ff;

      if (cmd.init) begin
         hash_in = INIT_HASH;
         pos_in  = 6'd0;
         cnt_in  = 64'd0;
      end

      if (cmd.byte_we) begin
         pos_in  = pos_ff + 6'd1;
         part_in = {part_ff[15:0], byte_val};
         // a completed big-endian word enters the schedule window
         if (pos_ff[1:0] == 2'b11) begin
            for (int i = 0; i < 15; i++) begin
               w_in[i] = w_ff[i + 1];
            end
            w_in[15] = {part_ff, byte_val};
         end
         if (cmd.count_en) begin
            cnt_in = cnt_ff + 64'd8;
         end
      end

      if (cmd.load_work) begin
         work_in = hash_ff;
      end

      if (cmd.round_en) begin
         for (int i = 0; i < 15; i++) begin
            w_in[i] = w_ff[i + 1];
         end
         w_in[15]   = sched;
         work_in[7] = work_ff[6];
         work_in[6] = work_ff[5];
         work_in[5] = work_ff[4];
         work_in[4] = work_ff[3] + t1;
         work_in[3] = work_ff[2];
         work_in[2] = work_ff[1];
         work_in[1] = work_ff[0];
         work_in[0] = t1 + t2;
      end

      if (cmd.fold) begin
         for (int i = 0; i < 8; i++) begin
            hash_in[i] = hash_ff[i] + work_ff[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hash_ff <= INIT_HASH;
         pos_ff  <= 6'd0;
         cnt_ff  <= 64'd0;
      end else begin
         hash_ff <= hash_in;
         pos_ff  <= pos_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      work_ff <= work_in;
      w_ff    <= w_in;
      part_ff <= part_in;
   end

   assign pos    = pos_ff;
   assign digest = {hash_ff[{cmd.oidx, 1'b0}], hash_ff[{cmd.oidx, 1'b1}]};

endmodule

// File: sv/shs_ctrl.sv
module shs_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic                 req_present,
   input  logic                 req_tlast,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [1:0]           rsp_index,
   output logic                 rsp_tlast,
   input  logic [5:0]           pos,
   output shs_pkg::shs_cmd_type cmd
);
   import shs_pkg::*;

   shs_state_type state_ff;
   shs_state_type state_in;
   logic [5:0]    rnd_ff;
   logic [5:0]    rnd_in;
   logic [1:0]    oidx_ff;
   logic [1:0]    oidx_in;
   logic          pend_ff;
   logic          pend_in;
   logic          mark_ff;
   logic          mark_in;
   logic          extra_ff;
   logic          extra_in;
   logic          final_ff;
   logic          final_in;

   logic req_acc;
   logic tail_zone;

   assign req_acc   = req_tvalid && (state_ff == ST_ABSORB);
   assign tail_zone = pos inside {[6'd56:6'd63]};

   always_comb begin
      state_in = state_ff;
      rnd_in   = rnd_ff;
      oidx_in  = oidx_ff;
      pend_in  = pend_ff;
      mark_in  = mark_ff;
      extra_in = extra_ff;
      final_in = final_ff;
      case (state_ff)
         ST_ABSORB: begin
            if (req_acc) begin
               if (req_tlast) begin
                  pend_in  = 1'b1;
                  mark_in  = 1'b1;
                  extra_in = 1'b0;
                  final_in = 1'b0;
               end
               if (req_present && pos == LAST_POS) begin
                  state_in = ST_ROUND;
               end else if (req_tlast) begin
                  state_in = ST_PAD;
               end
            end
         end
         ST_PAD: begin
            if (mark_ff) begin
               mark_in = 1'b0;
               // no room left for the length after the mark: one more block
               extra_in = tail_zone && (pos != LAST_POS);
            end else if (pos == LAST_POS) begin
               final_in = !extra_ff;
               extra_in = 1'b0;
            end
            if (pos == LAST_POS) begin
               state_in = ST_ROUND;
            end
         end
         ST_ROUND: begin
            rnd_in = rnd_ff + 6'd1;
            if (rnd_ff == LAST_RND) begin
               state_in = ST_FOLD;
            end
         end
         ST_FOLD: begin
            if (final_ff) begin
               state_in = ST_EMIT;
            end else if (pend_ff) begin
               state_in = ST_PAD;
            end else begin
               state_in = ST_ABSORB;
            end
         end
         ST_EMIT: begin
            if (rsp_tready) begin
               oidx_in = oidx_ff + 2'd1;
               if (oidx_ff == LAST_WORD) begin
                  state_in = ST_ABSORB;
                  pend_in  = 1'b0;
                  final_in = 1'b0;
               end
            end
         end
         default: begin
            state_in = ST_ABSORB;
         end
      endcase
   end

   always_comb begin
      cmd           = '0;
      cmd.bsel      = BSEL_INPUT;
      cmd.rnd       = rnd_ff;
      cmd.oidx      = oidx_ff;
      req_tready    = 1'b0;
      rsp_tvalid    = 1'b0;
      rsp_index     = oidx_ff;
      rsp_tlast     = (oidx_ff == LAST_WORD);
      case (state_ff)
         ST_ABSORB: begin
            req_tready = 1'b1;
            if (req_acc && req_present) begin
               cmd.byte_we   = 1'b1;
               cmd.count_en  = 1'b1;
               cmd.load_work = (pos == LAST_POS);
            end
         end
         ST_PAD: begin
            cmd.byte_we   = 1'b1;
            cmd.load_work = (pos == LAST_POS);
            if (mark_ff) begin
               cmd.bsel = BSEL_MARK;
            end else if (tail_zone && !extra_ff) begin
               cmd.bsel = BSEL_LENGTH;
            end else begin
               cmd.bsel = BSEL_ZERO;
            end
         end
         ST_ROUND: begin
            cmd.round_en = 1'b1;
         end
         ST_FOLD: begin
            cmd.fold = 1'b1;
         end
         ST_EMIT: begin
            rsp_tvalid = 1'b1;
            cmd.init   = rsp_tready && (oidx_ff == LAST_WORD);
         end
         default: begin
            cmd.bsel = BSEL_INPUT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_ABSORB;
         rnd_ff   <= 6'd0;
         oidx_ff  <= 2'd0;
         pend_ff  <= 1'b0;
         mark_ff  <= 1'b0;
         extra_ff <= 1'b0;
         final_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rnd_ff   <= rnd_in;
         oidx_ff  <= oidx_in;
         pend_ff  <= pend_in;
         mark_ff  <= mark_in;
         extra_ff <= extra_in;
         final_ff <= final_in;
      end
   end

endmodule

// File: sv/sha256_stream_hasher_top.sv
// byte-serial sha-256 hasher
// req channel: one message byte per transaction; req_tuser marks whether req_tdata
// holds a byte, req_tlast ends the message (a byte in the same transaction is
// hashed first). rsp channel: four 64-bit digest words, big-endian, index in
// rsp_tuser, rsp_tlast on the fourth.
// throughput: one byte is taken per cycle while the block buffer fills; the
// 64th byte of a block starts the round unit, which runs one round per cycle,
// so each full block is followed by a compression (64 rounds, then an add into
// the hash) with req_tready low.
// end of message: padding is fed through the same byte path, one byte per
// cycle up to the end of the block, followed by one compression, or two when
// more than 55 bytes were buffered; the digest words then appear on rsp.
// after the last compression the digest words are sent one per cycle while
// rsp_tready is high; a stalled receiver holds the digest on rsp and req_tready
// stays low until the fourth word is taken; then the hash state reinitializes.
// reset (synchronous) loads the initial hash values and clears the byte and
// bit counters; no clearing pass is needed
module sha256_stream_hasher_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tuser,   // [0] byte_present
   input  logic        req_tlast,   // end_of_message
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // [63:0] digest_word
   output logic [1:0]  rsp_tuser,   // [1:0] word_index
   output logic        rsp_tlast    // last_word
);
   import shs_pkg::*;

   shs_cmd_type cmd;
   logic [5:0]  pos;

   shs_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_present (req_tuser),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_index   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .pos         (pos),
      .cmd         (cmd)
   );

   shs_datapath u_datapath (
      .clock   (clock),
      .reset   (reset),
      .cmd     (cmd),
      .in_byte (req_tdata),
      .pos     (pos),
      .digest  (rsp_tdata)
   );

endmodule

// File: dv/testbench.sv
module testbench;

   localparam int CLK_HALF = 4;
   localparam int CYCLE_LIMIT = 200000;
   localparam int HOLD_CYCLES = 300;
   localparam int DRAIN_CYCLES = 200;
   localparam logic [7:0] PAD_BYTE = 8'h80;

   localparam logic [32*8-1:0] IV_ALL = {
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   localparam logic [32*64-1:0] K_ALL = {
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   typedef struct {
      logic [7:0] data;
      logic       present;
      logic       eom;
   } msg_item_type;

   typedef struct {
      logic [63:0] word;
      logic [1:0]  idx;
      logic        last;
   } digest_word_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'h00;
   logic        req_tuser = 1'b0;
   logic        req_tlast = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [63:0] rsp_tdata;
   logic [1:0]  rsp_tuser;
   logic        rsp_tlast;

   sha256_stream_hasher_top i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),   // [7:0] data_byte
      .req_tuser  (req_tuser),   // [0] byte_present
      .req_tlast  (req_tlast),   // end_of_message
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),   // [63:0] digest_word
      .rsp_tuser  (rsp_tuser),   // [1:0] word_index
      .rsp_tlast  (rsp_tlast)    // last_word
   );

   // hash model state
   logic [7:0]  blk [64];
   logic [31:0] hw [8];
   logic [5:0]  fill;
   logic [63:0] nbits;

   msg_item_type    byte_q [$];
   digest_word_type digest_q [$];
   msg_item_type    cur;
   digest_word_type want;

   int errors = 0;
   int cycles = 0;
   int msgs_queued = 0;
   int items_offered = 0;
   int bytes_hashed = 0;
   int results_seen = 0;
   int req_gap = 0;
   int rsp_wait = 0;
   int hold_left = 0;
   logic hold_done = 1'b0;
   logic req_fire = 1'b0;
   logic rsp_fire = 1'b0;

   initial begin
      forever #(CLK_HALF) clock = ~clock;
   end

   function automatic logic [31:0] rotr(logic [31:0] x, int n);
      return (x >> n) | (x << (32 - n));
   endfunction

   task automatic hash_reinit();
      for (int r = 0; r < 8; r++) hw[r] = IV_ALL[32*(7-r) +: 32];
      fill = '0;
      nbits = '0;
   endtask

   task automatic compress_block();
      logic [31:0] w [64];
      logic [31:0] a, b, c, d, e, f, g, h, t1, t2, s0, s1;
      for (int r = 0; r < 16; r++) w[r] = {blk[4*r], blk[4*r+1], blk[4*r+2], blk[4*r+3]};
      for (int r = 16; r < 64; r++) begin
         s0 = rotr(w[r-15], 7) ^ rotr(w[r-15], 18) ^ (w[r-15] >> 3);
         s1 = rotr(w[r-2], 17) ^ rotr(w[r-2], 19) ^ (w[r-2] >> 10);
         w[r] = s1 + w[r-7] + s0 + w[r-16];
      end
      a = hw[0]; b = hw[1]; c = hw[2]; d = hw[3];
      e = hw[4]; f = hw[5]; g = hw[6]; h = hw[7];
      for (int r = 0; r < 64; r++) begin
         t1 = h + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g))
            + K_ALL[32*(63-r) +: 32] + w[r];
         t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
         h = g; g = f; f = e; e = d + t1;
         d = c; c = b; b = a; a = t1 + t2;
      end
      hw[0] += a; hw[1] += b; hw[2] += c; hw[3] += d;
      hw[4] += e; hw[5] += f; hw[6] += g; hw[7] += h;
   endtask

   // absorb one accepted transaction, queue the digest words it finishes
   task automatic hash_step(logic [7:0] data, logic present, logic eom);
      int p;
      digest_word_type dw;
      if (present) begin
         blk[fill] = data;
         nbits += 64'd8;
         fill = fill + 6'd1;
         bytes_hashed++;
         if (fill == 6'd0) compress_block();
      end
      if (eom) begin
         p = int'(fill);
         blk[p] = PAD_BYTE;
         p++;
         // no room for the length: pad this block out, length goes in a second one
         if (p > 56) begin
            while (p < 64) begin
               blk[p] = 8'h00;
               p++;
            end
            compress_block();
            p = 0;
         end
         while (p < 56) begin
            blk[p] = 8'h00;
            p++;
         end
         for (int k = 0; k < 8; k++) blk[56+k] = nbits[63-8*k -: 8];
         compress_block();
         for (int k = 0; k < 4; k++) begin
            dw.word = {hw[2*k], hw[2*k+1]};
            dw.idx = 2'(k);
            dw.last = (2'(k) == shs_pkg::LAST_WORD);
            digest_q.push_back(dw);
         end
         hash_reinit();
      end
   endtask

   task automatic flag_error(string msg);
      $display("mismatch at cycle %0d: %s", cycles, msg);
      errors++;
   endtask

   task automatic queue_item(logic [7:0] data, logic present, logic eom);
      msg_item_type it;
      it.data = data;
      it.present = present;
      it.eom = eom;
      byte_q.push_back(it);
   endtask

   // random message, with ignored transactions sprinkled in
   task automatic queue_message(int nbytes);
      logic tail;
      tail = (nbytes > 0) && ($urandom_range(0, 1) == 1);
      for (int i = 0; i < nbytes; i++) begin
         if ($urandom_range(0, 7) == 0) queue_item(8'($urandom), 1'b0, 1'b0);
         queue_item(8'($urandom), 1'b1, tail && (i == nbytes - 1));
      end
      if (!tail) queue_item(8'($urandom), 1'b0, 1'b1);
      msgs_queued++;
   endtask

   // sender
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_fire) begin
         if (req_gap != 0) begin
            req_tvalid <= 1'b0;
            req_gap--;
         end else if (byte_q.size() != 0) begin
            cur = byte_q.pop_front();
            req_tdata <= cur.data;
            req_tuser <= cur.present;
            req_tlast <= cur.eom;
            req_tvalid <= 1'b1;
            items_offered++;
            req_gap = ((items_offered % 48) < 16) ? 0 : $urandom_range(0, 3);
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // receiver
   always @(negedge clock) begin
      if (rsp_fire) rsp_wait = ((results_seen % 24) < 8) ? 0 : $urandom_range(0, 3);
      if (hold_left != 0 || rsp_wait != 0) begin
         rsp_tready <= 1'b0;
         if (hold_left == 0) rsp_wait--;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // one long receiver stall while a digest is pending, so the input backs up
   always @(negedge clock) begin
      if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end else if (!hold_done && results_seen >= 8 && rsp_tvalid) begin
         hold_left <= HOLD_CYCLES;
         hold_done <= 1'b1;
      end
   end

   // monitor and predictor
   always @(posedge clock) begin
      req_fire <= !reset && req_tvalid && req_tready;
      rsp_fire <= !reset && rsp_tvalid && rsp_tready;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (digest_q.size() == 0) begin
            flag_error($sformatf("unexpected digest word %h", rsp_tdata));
         end else begin
            want = digest_q.pop_front();
            if (rsp_tdata !== want.word)
               flag_error($sformatf("digest word %h, wanted %h", rsp_tdata, want.word));
            if (rsp_tuser !== want.idx)
               flag_error($sformatf("word index %0d, wanted %0d", rsp_tuser, want.idx));
            if (rsp_tlast !== want.last)
               flag_error($sformatf("last flag %b, wanted %b", rsp_tlast, want.last));
         end
         results_seen++;
      end
      if (!reset && req_tvalid && req_tready) hash_step(req_tdata, req_tuser, req_tlast);
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("FAILURE");
         $finish;
      end
   end

   initial begin
      int n;
      for (int r = 0; r < 64; r++) blk[r] = 8'h00;
      hash_reinit();

      // empty message, ignored transaction, lone zero byte with end mark
      queue_item(8'h00, 1'b0, 1'b1);
      queue_item(8'hff, 1'b0, 1'b0);
      queue_item(8'h00, 1'b1, 1'b1);
      msgs_queued += 2;
      // "abc", end mark alone with junk on the data lines
      queue_item(8'h61, 1'b1, 1'b0);
      queue_item(8'h62, 1'b1, 1'b0);
      queue_item(8'h63, 1'b1, 1'b0);
      queue_item(8'hff, 1'b0, 1'b1);
      // all-ones byte, ignored byte in the middle, pad value as data
      queue_item(8'hff, 1'b1, 1'b0);
      queue_item(8'h5a, 1'b0, 1'b0);
      queue_item(PAD_BYTE, 1'b1, 1'b1);
      msgs_queued += 2;

      // exactly one full block, then one that needs the extra length block
      queue_message(64);
      queue_message(56);
      while (byte_q.size() < 120) begin
         n = $urandom_range(0, 9);
         if (n < 7) queue_message($urandom_range(0, 12));
         else if (n < 9) queue_message(55 + $urandom_range(0, 10));
         else queue_message($urandom_range(110, 130));
      end

      repeat (5) @(negedge clock);
      reset <= 1'b0;

      while (byte_q.size() != 0 || req_tvalid || digest_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("hashed %0d messages, %0d bytes in %0d transactions", msgs_queued,
               bytes_hashed, items_offered);
      $display("checked %0d digest words, %0d mismatches", results_seen, errors);
      if (errors == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

// File: filelist.f
sv/shs_pkg.sv
sv/shs_datapath.sv
sv/shs_ctrl.sv
sv/sha256_stream_hasher_top.sv
dv/testbench.sv
